@@ rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants of the SOH/STX/ETX frame checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

  // frame marks
  localparam logic [7:0] MarkSoh = 8'h01;
  localparam logic [7:0] MarkStx = 8'h02;
  localparam logic [7:0] MarkEtx = 8'h03;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned PosW    = LenW + 1;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PosW-1:0] ShortestFrame = PosW'(5);
  localparam logic [PosW-1:0] PayloadFirst  = PosW'(4);
  localparam logic [PosW-1:0] PosLimit      = {PosW{1'b1}};

  localparam logic [LenW-1:0] MinFrameReset = LenW'(5);
  localparam logic [LenW-1:0] MaxFrameReset = LenW'(5005);

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegMinFrame = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxFrame = 1'b1;

  // command queue between the front and the back part
  localparam int unsigned QueueDepth = 3;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [StatusW-1:0] {
    StOk          = 3'd0,
    StTooShort    = 3'd1,
    StBadSoh      = 3'd2,
    StBadStx      = 3'd3,
    StBadEtx      = 3'd4,
    StSizeRange   = 3'd5,
    StLenMismatch = 3'd6
  } status_e;

  // one queue entry: the results caused by one input byte
  typedef struct packed {
    logic             has_payload;
    logic [ByteW-1:0] payload_byte;
    logic             has_verdict;
    status_e          status;
    logic [LenW-1:0]  declared_length;
  } cmd_t;

endpackage

@@ rtl/sfc_if.sv @@
// ----------------------------------------------------------------------------
// sfc channel interfaces
// Valid/ready channels for input bytes, results and register writes.
// ----------------------------------------------------------------------------
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface sfc_out_if;
  logic        valid;
  logic        ready;
  logic        is_verdict;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [15:0] declared_length;
  logic        last_of_run;

  modport source (output valid, output is_verdict, output payload_byte, output status,
                  output declared_length, output last_of_run, input ready);
  modport sink (input valid, input is_verdict, input payload_byte, input status,
                input declared_length, input last_of_run, output ready);
endinterface

interface sfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/sfc_front.sv @@
// ----------------------------------------------------------------------------
// sfc_front
// Accepts bytes, tracks the header, holds back payload bytes and builds the
// verdict on the final byte; pushes one command per byte that causes results.
// ----------------------------------------------------------------------------
module sfc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sfc_in_if.sink               in_i,
  sfc_cfg_if.sink              cfg_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output sfc_pkg::cmd_t        q_cmd_o
);

  logic [sfc_pkg::LenW-1:0]  min_frame_q, max_frame_q;
  logic [sfc_pkg::PosW-1:0]  pos_q, size;
  logic [sfc_pkg::LenW-1:0]  len_q, len_d;
  logic                      soh_ok_q, soh_ok_d, stx_ok_q, stx_ok_d;
  logic [sfc_pkg::ByteW-1:0] held_q;
  logic                      held_vld_q;
  logic                      accept, payload_pos;
  sfc_pkg::status_e          status;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  assign payload_pos = pos_q >= sfc_pkg::PayloadFirst;
  assign size        = (pos_q == sfc_pkg::PosLimit) ? sfc_pkg::PosLimit
                                                    : pos_q + sfc_pkg::PosW'(1);

  always_comb begin
    len_d    = len_q;
    soh_ok_d = soh_ok_q;
    stx_ok_d = stx_ok_q;
    priority if (pos_q == sfc_pkg::PosW'(0)) begin
      soh_ok_d = (in_i.data_byte == sfc_pkg::MarkSoh);
    end else if (pos_q == sfc_pkg::PosW'(1)) begin
      len_d = {in_i.data_byte, 8'h00};
    end else if (pos_q == sfc_pkg::PosW'(2)) begin
      len_d = {len_q[15:8], in_i.data_byte};
    end else if (pos_q == sfc_pkg::PosW'(3)) begin
      stx_ok_d = (in_i.data_byte == sfc_pkg::MarkStx);
    end else begin
    end
  end

  always_comb begin
    priority if (size < sfc_pkg::ShortestFrame) begin
      status = sfc_pkg::StTooShort;
    end else if (!soh_ok_d) begin
      status = sfc_pkg::StBadSoh;
    end else if (!stx_ok_d) begin
      status = sfc_pkg::StBadStx;
    end else if (in_i.data_byte != sfc_pkg::MarkEtx) begin
      status = sfc_pkg::StBadEtx;
    end else if (size < {1'b0, min_frame_q} || size > {1'b0, max_frame_q}) begin
      status = sfc_pkg::StSizeRange;
    end else if ({1'b0, len_d} != size) begin
      status = sfc_pkg::StLenMismatch;
    end else begin
      status = sfc_pkg::StOk;
    end
  end

  always_comb begin
    q_cmd_o.has_payload     = payload_pos && held_vld_q;
    q_cmd_o.payload_byte    = held_q;
    q_cmd_o.has_verdict     = in_i.end_of_buffer;
    q_cmd_o.status          = status;
    // length field reads as zero until both of its bytes are in
    q_cmd_o.declared_length = (size >= sfc_pkg::PosW'(3)) ? len_d : '0;
  end

  assign q_push_o = accept && (q_cmd_o.has_payload || q_cmd_o.has_verdict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_frame_q <= sfc_pkg::MinFrameReset;
      max_frame_q <= sfc_pkg::MaxFrameReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        sfc_pkg::RegMinFrame: min_frame_q <= cfg_i.wdata;
        sfc_pkg::RegMaxFrame: max_frame_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      soh_ok_q   <= 1'b0;
      stx_ok_q   <= 1'b0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else if (accept) begin
      if (in_i.end_of_buffer) begin
        // buffer done, back to a clean frame
        pos_q      <= '0;
        len_q      <= '0;
        soh_ok_q   <= 1'b0;
        stx_ok_q   <= 1'b0;
        held_q     <= '0;
        held_vld_q <= 1'b0;
      end else begin
        pos_q    <= size;
        len_q    <= len_d;
        soh_ok_q <= soh_ok_d;
        stx_ok_q <= stx_ok_d;
        if (payload_pos) begin
          held_q     <= in_i.data_byte;
          held_vld_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/sfc_queue.sv @@
// ----------------------------------------------------------------------------
// sfc_queue
// Small command queue that decouples the front from the result stage.
// ----------------------------------------------------------------------------
module sfc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output sfc_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  sfc_pkg::cmd_t                  entries_q [sfc_pkg::QueueDepth];
  logic [sfc_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [sfc_pkg::QueueCntW-1:0]  count_q;
  logic                           do_push, do_pop;

  assign full_o  = count_q == sfc_pkg::QueueCntW'(sfc_pkg::QueueDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  function automatic logic [sfc_pkg::QueuePtrW-1:0] next_ptr(
    input logic [sfc_pkg::QueuePtrW-1:0] ptr
  );
    return (ptr == sfc_pkg::QueuePtrW'(sfc_pkg::QueueDepth - 1))
           ? '0 : ptr + sfc_pkg::QueuePtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + sfc_pkg::QueueCntW'(1);
        2'b01:   count_q <= count_q - sfc_pkg::QueueCntW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/sfc_back.sv @@
// ----------------------------------------------------------------------------
// sfc_back
// Result stage: expands each queued command into its payload result and
// verdict result and holds them in the output register.
// ----------------------------------------------------------------------------
module sfc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfc_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  sfc_out_if.source     out_o
);

  logic                      out_vld_q;
  logic                      verdict_next_q;
  logic                      load, emit_payload;
  logic                      is_verdict_q;
  logic [sfc_pkg::ByteW-1:0] payload_q;
  sfc_pkg::status_e          status_q;
  logic [sfc_pkg::LenW-1:0]  len_q;

  // output register free for a new transaction and a command waiting in the queue
  assign load         = (!out_vld_q || out_o.ready) && !empty_i;
  assign emit_payload = cmd_i.has_payload && !verdict_next_q;
  assign pop_o        = load && !(emit_payload && cmd_i.has_verdict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q      <= 1'b0;
      verdict_next_q <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q      <= 1'b1;
        verdict_next_q <= emit_payload && cmd_i.has_verdict;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (emit_payload) begin
        is_verdict_q <= 1'b0;
        payload_q    <= cmd_i.payload_byte;
        status_q     <= sfc_pkg::StOk;
        len_q        <= '0;
      end else begin
        is_verdict_q <= 1'b1;
        payload_q    <= '0;
        status_q     <= cmd_i.status;
        len_q        <= cmd_i.declared_length;
      end
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.is_verdict      = is_verdict_q;
  assign out_o.payload_byte    = payload_q;
  assign out_o.status          = sfc_pkg::StatusW'(status_q);
  assign out_o.declared_length = len_q;
  assign out_o.last_of_run     = is_verdict_q;

endmodule

@@ rtl/soh_stx_etx_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// soh_stx_etx_frame_checker_top
// Checks SOH / length / STX / payload / ETX frames one byte per transaction.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while the command queue is not full. Payload
// bytes come out one byte late and are tentative until the verdict, which
// follows the final byte of each buffer with status and declared length. The
// result register emits one transaction per clock while the receiver is
// ready; a final byte that releases a payload byte as well as the verdict
// needs two result transactions, which the three-entry command queue absorbs,
// so the input keeps one byte per clock unless the result side stalls. A
// result passes from the command queue into the output register, later
// while earlier results still wait; the verdict follows a released payload.
// Registers min/max frame size may be written while the checker is idle.
module soh_stx_etx_frame_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfc_in_if.sink     in_i,
  sfc_cfg_if.sink    cfg_i,
  sfc_out_if.source  out_o
);

  logic          q_push, q_full, q_pop, q_empty;
  sfc_pkg::cmd_t push_cmd, head_cmd;

  sfc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  sfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  sfc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

@@ tb/sv/soh_stx_etx_frame_checker_top_test.sv @@
// ----------------------------------------------------------------------------
// soh_stx_etx_frame_checker_top_test
// Self-checking testbench of the SOH/STX/ETX frame checker. Buffers are sent
// one byte per transaction on the input channel. A behavioural copy of the
// checker predicts the payload and verdict transactions, and every result is
// compared field by field in order of arrival. The run covers directed
// frames, the size limit registers, a long back-pressure stretch and random
// buffers with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module soh_stx_etx_frame_checker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 2;
  localparam int StallLimit = 2000;
  localparam int MaxReports = 100;
  localparam int SettleWait = 8;

  typedef struct packed {
    logic                      is_verdict;
    logic [sfc_pkg::ByteW-1:0] payload_byte;
    sfc_pkg::status_e          status;
    logic [sfc_pkg::LenW-1:0]  declared_length;
    logic                      last_of_run;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sfc_in_if  in_if ();
  sfc_out_if out_if ();
  sfc_cfg_if cfg_if ();

  soh_stx_etx_frame_checker_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // behavioural copy of the checker
  logic [sfc_pkg::PosW-1:0]  frame_pos      = '0;
  logic [sfc_pkg::LenW-1:0]  frame_len      = '0;
  logic                      soh_seen_ok    = 1'b0;
  logic                      stx_seen_ok    = 1'b0;
  logic [sfc_pkg::ByteW-1:0] held_payload   = '0;
  logic                      held_payload_v = 1'b0;
  logic [sfc_pkg::LenW-1:0]  min_size       = sfc_pkg::MinFrameReset;
  logic [sfc_pkg::LenW-1:0]  max_size       = sfc_pkg::MaxFrameReset;

  frame_result_t pending_results[$];

  int fail_count  = 0;
  int items_sent  = 0;
  int stall_count = 0;

  // sender pacing
  int gap_max    = 0;
  int burst_left = 1;

  // receiver pattern
  int rx_mode      = 0;
  int rx_period    = 5;
  int rx_low       = 1;
  int rx_count     = 0;
  int hold_request = 0;
  int hold_left    = 0;

  function automatic void track_frame_byte(logic [sfc_pkg::ByteW-1:0] b, logic eob);
    logic [sfc_pkg::PosW-1:0] size;
    frame_result_t            res;
    if (frame_pos == 0) begin
      soh_seen_ok = (b == sfc_pkg::MarkSoh);
    end else if (frame_pos == 1) begin
      frame_len = {b, 8'h00};
    end else if (frame_pos == 2) begin
      frame_len[7:0] = b;
    end else if (frame_pos == 3) begin
      stx_seen_ok = (b == sfc_pkg::MarkStx);
    end else begin
      // payload goes out one byte late, so the closing mark never does
      if (held_payload_v) begin
        res = '{is_verdict: 1'b0, payload_byte: held_payload, status: sfc_pkg::StOk,
                declared_length: '0, last_of_run: 1'b0};
        pending_results = {pending_results, res};
      end
      held_payload   = b;
      held_payload_v = 1'b1;
    end
    size      = (frame_pos == sfc_pkg::PosLimit) ? sfc_pkg::PosLimit : frame_pos + 1'b1;
    frame_pos = size;
    if (eob) begin
      res = '{is_verdict: 1'b1, payload_byte: '0, status: sfc_pkg::StOk,
              declared_length: (size >= 3) ? frame_len : '0, last_of_run: 1'b1};
      if (size < sfc_pkg::ShortestFrame) res.status = sfc_pkg::StTooShort;
      else if (!soh_seen_ok) res.status = sfc_pkg::StBadSoh;
      else if (!stx_seen_ok) res.status = sfc_pkg::StBadStx;
      else if (b != sfc_pkg::MarkEtx) res.status = sfc_pkg::StBadEtx;
      else if (size < {1'b0, min_size} || size > {1'b0, max_size})
        res.status = sfc_pkg::StSizeRange;
      else if ({1'b0, frame_len} != size) res.status = sfc_pkg::StLenMismatch;
      pending_results = {pending_results, res};
      frame_pos      = '0;
      frame_len      = '0;
      soh_seen_ok    = 1'b0;
      stx_seen_ok    = 1'b0;
      held_payload   = '0;
      held_payload_v = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      // keep the log short when a whole long buffer goes wrong
      if (fail_count <= MaxReports) $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $error("unexpected result: is_verdict %0b payload_byte %0h status %0d",
                 out_if.is_verdict, out_if.payload_byte, out_if.status);
      end else begin
        want = pending_results.pop_front();
        check_field("is_verdict", want.is_verdict, out_if.is_verdict);
        check_field("payload_byte", want.payload_byte, out_if.payload_byte);
        check_field("status", want.status, out_if.status);
        check_field("declared_length", want.declared_length, out_if.declared_length);
        check_field("last_of_run", want.last_of_run, out_if.last_of_run);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: hold-off on request, otherwise its own stall pattern
  always @(negedge clk) begin
    rx_count++;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((rx_count % rx_period) >= rx_low);
      endcase
    end
  end

  // called at a falling edge, returns at a falling edge; valid stays set unless a gap in the burst cleared it
  task automatic send_byte(input logic [sfc_pkg::ByteW-1:0] b, input logic eob);
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.end_of_buffer <= eob;
    do @(posedge clk); while (!in_if.ready);
    track_frame_byte(b, eob);
    items_sent++;
    @(negedge clk);
    if (gap_max > 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic send_buffer(input logic [sfc_pkg::ByteW-1:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic send_frame(input int size, input logic [sfc_pkg::LenW-1:0] decl,
                            input logic [sfc_pkg::ByteW-1:0] soh,
                            input logic [sfc_pkg::ByteW-1:0] stx,
                            input logic [sfc_pkg::ByteW-1:0] etx);
    logic [sfc_pkg::ByteW-1:0] b;
    for (int i = 0; i < size; i++) begin
      case (i)
        0: b = soh;
        1: b = decl[15:8];
        2: b = decl[7:0];
        3: b = stx;
        default: b = (i == size - 1) ? etx : 8'($urandom);
      endcase
      send_byte(b, i == size - 1);
    end
  endtask

  // idle the input and wait until every result is back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sfc_pkg::CfgIdxW-1:0] idx,
                           input logic [sfc_pkg::LenW-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == sfc_pkg::RegMinFrame) min_size = val;
    else max_size = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed_frames();
    gap_max = 0;
    rx_mode = 0;
    send_buffer('{8'h01, 8'h00, 8'h07, 8'h02, 8'h00, 8'hFF, 8'h03});
    send_buffer('{8'hFF});
    send_buffer('{8'h01, 8'h12, 8'h34, 8'h02});
    send_frame(5, 16'd5, 8'h00, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    send_frame(5, 16'd5, sfc_pkg::MarkSoh, 8'hFD, sfc_pkg::MarkEtx);
    send_frame(5, 16'd5, sfc_pkg::MarkSoh, sfc_pkg::MarkStx, 8'hFC);
    send_frame(6, 16'hFFFF, sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    settle();
  endtask

  task automatic test_size_limits();
    write_reg(sfc_pkg::RegMinFrame, 16'd6);
    send_frame(5, 16'd5, sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    write_reg(sfc_pkg::RegMinFrame, 16'd5);
    write_reg(sfc_pkg::RegMaxFrame, 16'd5);
    send_frame(5, 16'd5, sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    send_frame(6, 16'd6, sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    // minimum above maximum: nothing is in range
    write_reg(sfc_pkg::RegMinFrame, 16'd10);
    write_reg(sfc_pkg::RegMaxFrame, 16'd9);
    send_frame(9, 16'd9, sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    send_frame(10, 16'd10, sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    write_reg(sfc_pkg::RegMinFrame, sfc_pkg::MinFrameReset);
    write_reg(sfc_pkg::RegMaxFrame, sfc_pkg::MaxFrameReset);
  endtask

  task automatic test_back_pressure();
    int sz;
    gap_max = 0;
    rx_mode = 1;
    @(posedge clk);
    hold_request = 300;
    @(negedge clk);
    repeat (6) begin
      sz = $urandom_range(6, 14);
      send_frame(sz, 16'(sz), sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    end
    settle();
  endtask

  task automatic send_random_buffer();
    int kind;
    int sz;
    logic [sfc_pkg::ByteW-1:0] noise[$];
    kind = $urandom_range(0, 99);
    sz   = ($urandom_range(0, 19) == 0) ? $urandom_range(29, 300) : $urandom_range(5, 28);
    if (kind < 60) begin
      send_frame(sz, 16'(sz), sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    end else if (kind < 68) begin
      send_frame(sz, 16'(sz), 8'($urandom), sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    end else if (kind < 76) begin
      send_frame(sz, 16'(sz), sfc_pkg::MarkSoh, 8'($urandom), sfc_pkg::MarkEtx);
    end else if (kind < 84) begin
      send_frame(sz, 16'(sz), sfc_pkg::MarkSoh, sfc_pkg::MarkStx, 8'($urandom));
    end else if (kind < 92) begin
      send_frame(sz, $urandom_range(0, 1) ? 16'(sz + 1) : 16'($urandom),
                 sfc_pkg::MarkSoh, sfc_pkg::MarkStx, sfc_pkg::MarkEtx);
    end else begin
      // truncated frame or plain noise
      sz = (kind < 96) ? $urandom_range(1, 4) : $urandom_range(1, 16);
      for (int i = 0; i < sz; i++)
        noise = {noise, (kind < 96 && i == 0) ? sfc_pkg::MarkSoh : 8'($urandom)};
      send_buffer(noise);
    end
  endtask

  task automatic pick_size_limits();
    logic [sfc_pkg::LenW-1:0] lo;
    logic [sfc_pkg::LenW-1:0] hi;
    case ($urandom_range(0, 4))
      0: begin
        lo = sfc_pkg::MinFrameReset;
        hi = sfc_pkg::MaxFrameReset;
      end
      1: begin
        lo = 16'($urandom_range(5, 20));
        hi = 16'($urandom_range(lo, 30));
      end
      2: begin
        lo = 16'($urandom_range(10, 30));
        hi = 16'($urandom_range(5, lo - 1));
      end
      3: begin
        lo = 16'd5;
        hi = 16'hFFFF;
      end
      default: begin
        lo = 16'($urandom_range(5, 65535));
        hi = 16'($urandom_range(5, 65535));
      end
    endcase
    write_reg(sfc_pkg::RegMinFrame, lo);
    write_reg(sfc_pkg::RegMaxFrame, hi);
  endtask

  task automatic test_random_frames();
    int goal;
    for (int phase = 0; phase < 6; phase++) begin
      pick_size_limits();
      gap_max   = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 3 : 12;
      rx_mode   = (phase / 2) % 3;
      rx_period = $urandom_range(3, 9);
      rx_low    = $urandom_range(1, 2);
      goal      = items_sent + 180;
      while (items_sent < goal) send_random_buffer();
      settle();
    end
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_buffer = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.wdata        = '0;
    out_if.ready        = 1'b0;
    rst_n               = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_frames();
    test_size_limits();
    test_back_pressure();
    test_random_frames();
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sfc_pkg.sv
rtl/sfc_if.sv
rtl/sfc_front.sv
rtl/sfc_queue.sv
rtl/sfc_back.sv
rtl/soh_stx_etx_frame_checker_top.sv
tb/sv/soh_stx_etx_frame_checker_top_test.sv
